FILE: sv/rnpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnpp_pkg
// Shared constants, widths and operation codes for the ray nearest point
// picker.
// ----------------------------------------------------------------------------
package rnpp_pkg;

    localparam int NUM_POINTS = 16;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int THR_BITS   = 16;
    localparam int SLOT_BITS  = 4;
    localparam int IDX_BITS   = $clog2(NUM_POINTS);

    localparam int W_BITS     = COORD_BITS + 1;
    localparam int P_BITS     = W_BITS + COORD_BITS;
    localparam int C_BITS     = P_BITS + 1;
    localparam int SQ_BITS    = 2 * C_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int DSQ_BITS   = 2 * COORD_BITS;
    localparam int DSUM_BITS  = DSQ_BITS + 2;
    localparam int LIM_BITS   = THR_BITS + DSUM_BITS + FRAC_BITS;
    localparam int CMP_BITS   = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;
    localparam int PT_BITS    = 3 * COORD_BITS;

    localparam logic [THR_BITS-1:0] THR_RESET = 16'd26;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_PICK    = 2'd1;
    localparam logic [1:0] MODE_MOVE    = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

endpackage

FILE: sv/ray_nearest_point_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_nearest_point_picker
// Holds control points and picks the one nearest to a ray by the squared
// cross-product length, with load, move and release of the selection.
// ----------------------------------------------------------------------------
// Load, move and release requests, and a pick with a zero direction, finish
// without a sweep; their result is registered at the accepting edge. A pick
// with a nonzero direction reads the point memory once per cycle for every
// stored point through its single read port and runs each point through a
// seven-stage distance pipeline; its result is registered once the last point
// has left it and the output is free. Only one request is in work at a time.
module ray_nearest_point_picker
    import rnpp_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [THR_BITS-1:0]          cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_mode,
    input  logic [SLOT_BITS-1:0]         s_point_index,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [COORD_BITS-1:0] s_coord_z,
    input  logic signed [COORD_BITS-1:0] s_dir_x,
    input  logic signed [COORD_BITS-1:0] s_dir_y,
    input  logic signed [COORD_BITS-1:0] s_dir_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_has_selection,
    output logic [SLOT_BITS-1:0]         m_selected_slot
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [THR_BITS-1:0]          thr_reg;
    logic                         sel_valid_reg, sel_valid_next;
    logic [SLOT_BITS-1:0]         sel_slot_reg, sel_slot_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_has_reg, m_has_next;
    logic [SLOT_BITS-1:0]         m_slot_reg, m_slot_next;
    logic [IDX_BITS-1:0]          cnt_reg, cnt_next;

    logic [PT_BITS-1:0]           mem [NUM_POINTS];
    logic [PT_BITS-1:0]           rdata_reg;
    logic                         wr_en;
    logic [IDX_BITS-1:0]          wr_addr;
    logic                         rd_en;

    logic signed [COORD_BITS-1:0] ox_reg, oy_reg, oz_reg;
    logic signed [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg;

    logic [7:1]                   pv_reg;
    logic [IDX_BITS-1:0]          idx_reg [1:7];
    logic signed [W_BITS-1:0]     wx_reg, wy_reg, wz_reg;
    logic signed [P_BITS-1:0]     p_reg [6];
    logic signed [C_BITS-1:0]     cx_reg, cy_reg, cz_reg;
    logic [C_BITS-1:0]            mx_reg, my_reg, mz_reg;
    logic [SQ_BITS-1:0]           sx_reg, sy_reg, sz_reg;
    logic [SUM_BITS-1:0]          sum_reg;
    logic [SUM_BITS-1:0]          best_reg;
    logic [IDX_BITS-1:0]          best_idx_reg;

    logic [DSQ_BITS-1:0]          dsq_reg [3];
    logic [DSUM_BITS-1:0]         dsum_reg;
    logic [LIM_BITS-1:0]          limit_reg;

    logic signed [COORD_BITS-1:0] rx, ry, rz;
    logic                         accept;
    logic                         out_free;
    logic                         dir_zero;
    logic                         last_point;
    logic                         pick_ok;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && out_free;
    assign dir_zero   = (s_dir_x == '0) && (s_dir_y == '0) && (s_dir_z == '0);
    assign last_point = pv_reg[7] && (idx_reg[7] == IDX_BITS'(NUM_POINTS - 1));
    assign pick_ok    = CMP_BITS'(best_reg) <= CMP_BITS'(limit_reg);
    assign rd_en      = (state_reg == ST_SWEEP);

    assign m_valid         = m_valid_reg;
    assign m_has_selection = m_has_reg;
    assign m_selected_slot = m_slot_reg;

    always_comb begin
        state_next     = state_reg;
        sel_valid_next = sel_valid_reg;
        sel_slot_next  = sel_slot_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_has_next     = m_has_reg;
        m_slot_next    = m_slot_reg;
        cnt_next       = cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = s_point_index[IDX_BITS-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_LOAD: begin
                            wr_en = (32'(s_point_index) < NUM_POINTS);
                        end
                        MODE_PICK: begin
                            if (dir_zero) begin
                                sel_valid_next = 1'b0;
                                sel_slot_next  = '0;
                            end else begin
                                state_next = ST_SWEEP;
                                cnt_next   = '0;
                            end
                        end
                        MODE_MOVE: begin
                            wr_en   = sel_valid_reg;
                            wr_addr = sel_slot_reg[IDX_BITS-1:0];
                        end
                        default: begin
                            sel_valid_next = 1'b0;
                            sel_slot_next  = '0;
                        end
                    endcase
                    if (s_mode != MODE_PICK || dir_zero) begin
                        m_valid_next = 1'b1;
                        m_has_next   = sel_valid_next;
                        m_slot_next  = sel_slot_next;
                    end
                end
            end
            ST_SWEEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_BITS'(NUM_POINTS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (last_point) begin
                    state_next = ST_FINISH;
                end
            end
            default: begin
                if (out_free) begin
                    sel_valid_next = pick_ok;
                    sel_slot_next  = pick_ok ? SLOT_BITS'(best_idx_reg) : '0;
                    m_valid_next   = 1'b1;
                    m_has_next     = sel_valid_next;
                    m_slot_next    = sel_slot_next;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            sel_valid_reg <= 1'b0;
            sel_slot_reg  <= '0;
            m_valid_reg   <= 1'b0;
            pv_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            sel_valid_reg <= sel_valid_next;
            sel_slot_reg  <= sel_slot_next;
            m_valid_reg   <= m_valid_next;
            pv_reg        <= {pv_reg[6:1], rd_en};
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_has_reg  <= m_has_next;
        m_slot_reg <= m_slot_next;
        cnt_reg    <= cnt_next;
        if (accept) begin
            ox_reg <= s_coord_x;
            oy_reg <= s_coord_y;
            oz_reg <= s_coord_z;
            dx_reg <= s_dir_x;
            dy_reg <= s_dir_y;
            dz_reg <= s_dir_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {s_coord_z, s_coord_y, s_coord_x};
        end
        if (rd_en) begin
            rdata_reg <= mem[cnt_reg];
        end
    end

    assign rx = rdata_reg[COORD_BITS-1:0];
    assign ry = rdata_reg[2*COORD_BITS-1:COORD_BITS];
    assign rz = rdata_reg[3*COORD_BITS-1:2*COORD_BITS];

    always_ff @(posedge aclk) begin
        idx_reg[1] <= cnt_reg;
        for (int i = 2; i <= 7; i++) begin
            idx_reg[i] <= idx_reg[i-1];
        end

        wx_reg <= W_BITS'(rx) - W_BITS'(ox_reg);
        wy_reg <= W_BITS'(ry) - W_BITS'(oy_reg);
        wz_reg <= W_BITS'(rz) - W_BITS'(oz_reg);

        p_reg[0] <= P_BITS'(wy_reg) * P_BITS'(dz_reg);
        p_reg[1] <= P_BITS'(wz_reg) * P_BITS'(dy_reg);
        p_reg[2] <= P_BITS'(wz_reg) * P_BITS'(dx_reg);
        p_reg[3] <= P_BITS'(wx_reg) * P_BITS'(dz_reg);
        p_reg[4] <= P_BITS'(wx_reg) * P_BITS'(dy_reg);
        p_reg[5] <= P_BITS'(wy_reg) * P_BITS'(dx_reg);

        cx_reg <= C_BITS'(p_reg[0]) - C_BITS'(p_reg[1]);
        cy_reg <= C_BITS'(p_reg[2]) - C_BITS'(p_reg[3]);
        cz_reg <= C_BITS'(p_reg[4]) - C_BITS'(p_reg[5]);

        mx_reg <= cx_reg[C_BITS-1] ? C_BITS'(~cx_reg + 1'b1) : C_BITS'(cx_reg);
        my_reg <= cy_reg[C_BITS-1] ? C_BITS'(~cy_reg + 1'b1) : C_BITS'(cy_reg);
        mz_reg <= cz_reg[C_BITS-1] ? C_BITS'(~cz_reg + 1'b1) : C_BITS'(cz_reg);

        sx_reg <= SQ_BITS'(mx_reg) * SQ_BITS'(mx_reg);
        sy_reg <= SQ_BITS'(my_reg) * SQ_BITS'(my_reg);
        sz_reg <= SQ_BITS'(mz_reg) * SQ_BITS'(mz_reg);

        sum_reg <= SUM_BITS'(sx_reg) + SUM_BITS'(sy_reg) + SUM_BITS'(sz_reg);

        if (pv_reg[7] && (idx_reg[7] == '0 || sum_reg < best_reg)) begin
            best_reg     <= sum_reg;
            best_idx_reg <= idx_reg[7];
        end

        dsq_reg[0] <= DSQ_BITS'(dx_reg) * DSQ_BITS'(dx_reg);
        dsq_reg[1] <= DSQ_BITS'(dy_reg) * DSQ_BITS'(dy_reg);
        dsq_reg[2] <= DSQ_BITS'(dz_reg) * DSQ_BITS'(dz_reg);
        dsum_reg   <= DSUM_BITS'(dsq_reg[0]) + DSUM_BITS'(dsq_reg[1])
                    + DSUM_BITS'(dsq_reg[2]);
        limit_reg  <= LIM_BITS'(LIM_BITS'(thr_reg) * LIM_BITS'(dsum_reg)) << FRAC_BITS;
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("request accepted while a pick is in work");

    a_no_slot_without_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_selection) |-> (m_selected_slot == '0))
        else $error("slot reported without a selection");

    a_pick_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_PICK && !dir_zero) |=> (state_reg == ST_SWEEP))
        else $error("pick did not start the memory sweep");

    a_pipe_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pv_reg == '0))
        else $error("distance pipeline busy while idle");

endmodule
